/* sv/stl_pkg.sv */
// ============================================================================
// stl_pkg: shared types, codes and helper functions of the token lexer
// Character classes, token kinds, lexer modes and the keyword table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  // Token length field and its saturation point.
  localparam int LEN_W = 8;
  localparam logic [LEN_W-1:0] MAX_TOKEN_LEN = LEN_W'(255);
  localparam int KEYWORD_BYTES = 8;
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Queue sizes (power of two depths).
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);

  // Lexer modes.
  localparam logic [3:0] M_IDLE = 4'd0;
  localparam logic [3:0] M_NAME = 4'd1;
  localparam logic [3:0] M_NUM  = 4'd2;
  localparam logic [3:0] M_DASH = 4'd3;
  localparam logic [3:0] M_BANG = 4'd4;
  localparam logic [3:0] M_BAR  = 4'd5;
  localparam logic [3:0] M_AMP  = 4'd6;
  localparam logic [3:0] M_EQ   = 4'd7;
  localparam logic [3:0] M_LT   = 4'd8;
  localparam logic [3:0] M_GT   = 4'd9;

  // Token kinds.
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_INVALID  = 6'd1;
  localparam logic [5:0] K_NAME     = 6'd2;
  localparam logic [5:0] K_INTEGER  = 6'd3;
  localparam logic [5:0] K_MODULE   = 6'd4;
  localparam logic [5:0] K_STRUCT   = 6'd5;
  localparam logic [5:0] K_CONST    = 6'd6;
  localparam logic [5:0] K_FUNCTION = 6'd7;
  localparam logic [5:0] K_LBRACE   = 6'd8;
  localparam logic [5:0] K_RBRACE   = 6'd9;
  localparam logic [5:0] K_LPAREN   = 6'd10;
  localparam logic [5:0] K_RPAREN   = 6'd11;
  localparam logic [5:0] K_LBRACK   = 6'd12;
  localparam logic [5:0] K_RBRACK   = 6'd13;
  localparam logic [5:0] K_LT       = 6'd14;
  localparam logic [5:0] K_GT       = 6'd15;
  localparam logic [5:0] K_LARROW   = 6'd16;
  localparam logic [5:0] K_RARROW   = 6'd17;
  localparam logic [5:0] K_COMMA    = 6'd18;
  localparam logic [5:0] K_COLON    = 6'd19;
  localparam logic [5:0] K_SEMI     = 6'd20;
  localparam logic [5:0] K_ASSIGN   = 6'd21;
  localparam logic [5:0] K_PLUS     = 6'd22;
  localparam logic [5:0] K_MINUS    = 6'd23;
  localparam logic [5:0] K_STAR     = 6'd24;
  localparam logic [5:0] K_SLASH    = 6'd25;
  localparam logic [5:0] K_TILDE    = 6'd26;
  localparam logic [5:0] K_AMP      = 6'd27;
  localparam logic [5:0] K_BANG     = 6'd28;
  localparam logic [5:0] K_OROR     = 6'd29;
  localparam logic [5:0] K_ANDAND   = 6'd30;
  localparam logic [5:0] K_EQEQ     = 6'd31;
  localparam logic [5:0] K_NEQ      = 6'd32;
  localparam logic [5:0] K_LE       = 6'd33;
  localparam logic [5:0] K_GE       = 6'd34;
  // Returned by the lookups when the byte forms no token of that group.
  localparam logic [5:0] K_NONE     = 6'd0;

  // Keywords, packed most significant byte first.
  localparam logic [63:0] KW_MODULE   = 64'h0000_6d6f_6475_6c65;
  localparam logic [63:0] KW_STRUCT   = 64'h0000_7374_7275_6374;
  localparam logic [63:0] KW_CONST    = 64'h0000_0063_6f6e_7374;
  localparam logic [63:0] KW_FUNCTION = 64'h6675_6e63_7469_6f6e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [LEN_W-1:0] token_length;
    logic             length_saturated;
    logic [POS_W-1:0] start_line;
    logic [POS_W-1:0] start_column;
    logic             last_of_run;
  } token_t;

  typedef struct packed {
    logic       is_eoi;
    logic       is_print;
    logic       is_ws;
    logic       is_nl;
    logic       is_letter;
    logic       is_digit;
    logic [3:0] prefix;
    logic [5:0] single;
  } class_t;

  typedef struct packed {
    class_t     cls;
    logic [7:0] value;
  } front_word_t;

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h5b:   k = K_LBRACK;
      8'h5d:   k = K_RBRACK;
      8'h2c:   k = K_COMMA;
      8'h3a:   k = K_COLON;
      8'h3b:   k = K_SEMI;
      8'h2b:   k = K_PLUS;
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h7e:   k = K_TILDE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] prefix_mode(input logic [7:0] b);
    logic [3:0] m;
    unique case (b)
      8'h2d:   m = M_DASH;
      8'h21:   m = M_BANG;
      8'h7c:   m = M_BAR;
      8'h26:   m = M_AMP;
      8'h3d:   m = M_EQ;
      8'h3c:   m = M_LT;
      8'h3e:   m = M_GT;
      default: m = M_IDLE;
    endcase
    return m;
  endfunction

  function automatic class_t classify(input logic [7:0] b, input logic eoi);
    class_t c;
    c.is_eoi    = eoi;
    c.is_print  = (b >= 8'd32);
    c.is_ws     = (b == 8'h20) || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    c.is_nl     = (b == 8'h0a);
    c.is_letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || (b == 8'h5f);
    c.is_digit  = (b >= 8'h30 && b <= 8'h39);
    c.prefix    = prefix_mode(b);
    c.single    = single_kind(b);
    return c;
  endfunction

  // Kind of a lone operator prefix when no second byte completes it.
  function automatic logic [5:0] prefix_single_kind(input logic [3:0] m);
    logic [5:0] k;
    unique case (m)
      M_DASH:  k = K_MINUS;
      M_BANG:  k = K_BANG;
      M_BAR:   k = K_INVALID;
      M_AMP:   k = K_AMP;
      M_EQ:    k = K_ASSIGN;
      M_LT:    k = K_LT;
      default: k = K_GT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [3:0] m, input logic [7:0] b);
    logic [5:0] k;
    priority if (m == M_DASH && b == 8'h3e) k = K_RARROW;
    else if (m == M_BANG && b == 8'h3d) k = K_NEQ;
    else if (m == M_BAR && b == 8'h7c) k = K_OROR;
    else if (m == M_AMP && b == 8'h26) k = K_ANDAND;
    else if (m == M_EQ && b == 8'h3d) k = K_EQEQ;
    else if (m == M_LT && b == 8'h3d) k = K_LE;
    else if (m == M_LT && b == 8'h2d) k = K_LARROW;
    else if (m == M_GT && b == 8'h3d) k = K_GE;
    else k = K_NONE;
    return k;
  endfunction

endpackage

`default_nettype wire

/* sv/stl_front.sv */
// ============================================================================
// stl_front: input side of the token lexer
// Classifies each accepted byte and holds it in a short queue for the engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  stl_pkg::item_t           item,
  output logic                     full,
  output logic                     avail,
  output stl_pkg::front_word_t     head,
  input  wire logic                take
);
  import stl_pkg::*;

  front_word_t mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wp;
  logic [FQ_AW-1:0] rp;
  logic [FQ_AW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (FQ_AW+1)'(FQ_DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = take && avail;
  assign head    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp].cls   <= classify(item.in_byte, item.end_of_input);
      mem[wp].value <= item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + FQ_AW'(1);
      if (do_pop) rp <= rp + FQ_AW'(1);
      count <= count + (FQ_AW+1)'(do_push) - (FQ_AW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FQ_AW+1)'(FQ_DEPTH))
    else $error("front queue count exceeds depth");

endmodule

`default_nettype wire

/* sv/stl_engine.sv */
// ============================================================================
// stl_engine: token-building state machine
// Consumes classified bytes and produces up to two tokens per byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                go,
  input  stl_pkg::front_word_t     word,
  output logic                     w0_valid,
  output stl_pkg::token_t          w0,
  output logic                     w1_valid,
  output stl_pkg::token_t          w1
);
  import stl_pkg::*;

  logic [3:0]       mode,        mode_next;
  logic [63:0]      name_prefix, name_prefix_next;
  logic [LEN_W-1:0] plen,        plen_next;
  logic             psat,        psat_next;
  logic [POS_W-1:0] pline,       pline_next;
  logic [POS_W-1:0] pcol,        pcol_next;
  logic [POS_W-1:0] line,        line_next;
  logic [POS_W-1:0] col,         col_next;

  logic [5:0] name_kind;

  always_comb begin
    name_kind = K_NAME;
    if (!psat) begin
      priority if (plen == LEN_W'(6) && name_prefix == KW_MODULE) name_kind = K_MODULE;
      else if (plen == LEN_W'(6) && name_prefix == KW_STRUCT) name_kind = K_STRUCT;
      else if (plen == LEN_W'(5) && name_prefix == KW_CONST) name_kind = K_CONST;
      else if (plen == LEN_W'(KEYWORD_BYTES) && name_prefix == KW_FUNCTION)
        name_kind = K_FUNCTION;
      else name_kind = K_NAME;
    end
  end

  always_comb begin
    token_t     flush_tok;
    token_t     a_tok;
    token_t     b_tok;
    logic       a_v;
    logic       b_v;
    logic       pend;
    logic       is_pfx;
    logic       cont;
    logic [5:0] pk;
    logic [POS_W-1:0] col_in;
    class_t     c;

    c      = word.cls;
    is_pfx = (mode >= M_DASH) && (mode <= M_GT);
    pend   = (mode == M_NAME) || (mode == M_NUM) || is_pfx;
    pk     = pair_kind(mode, word.value);
    col_in = (c.is_print && col != POS_MAX) ? col + POS_W'(1) : col;

    flush_tok.start_line   = pline;
    flush_tok.start_column = pcol;
    flush_tok.last_of_run  = 1'b0;
    if (mode == M_NAME) begin
      flush_tok.token_kind       = name_kind;
      flush_tok.token_length     = plen;
      flush_tok.length_saturated = psat;
    end else if (mode == M_NUM) begin
      flush_tok.token_kind       = K_INTEGER;
      flush_tok.token_length     = plen;
      flush_tok.length_saturated = psat;
    end else begin
      flush_tok.token_kind       = prefix_single_kind(mode);
      flush_tok.token_length     = LEN_W'(1);
      flush_tok.length_saturated = 1'b0;
    end

    a_v   = 1'b0;
    b_v   = 1'b0;
    a_tok = flush_tok;
    b_tok = flush_tok;
    cont  = 1'b1;

    mode_next        = mode;
    name_prefix_next = name_prefix;
    plen_next        = plen;
    psat_next        = psat;
    pline_next       = pline;
    pcol_next        = pcol;
    line_next        = line;
    col_next         = col;

    if (c.is_eoi) begin
      a_v = pend;
      b_v = 1'b1;
      b_tok.token_kind       = K_EOF;
      b_tok.token_length     = '0;
      b_tok.length_saturated = 1'b0;
      b_tok.start_line       = line;
      b_tok.start_column     = col;
      mode_next        = M_IDLE;
      name_prefix_next = '0;
      plen_next        = '0;
      psat_next        = 1'b0;
      pline_next       = '0;
      pcol_next        = '0;
      line_next        = POS_W'(1);
      col_next         = '0;
    end else begin
      col_next = col_in;
      if ((mode == M_NAME && (c.is_letter || c.is_digit)) ||
          (mode == M_NUM && c.is_digit)) begin
        // Extend the pending name or number.
        cont = 1'b0;
        if (plen < LEN_W'(KEYWORD_BYTES))
          name_prefix_next = {name_prefix[55:0], word.value};
        if (plen < MAX_TOKEN_LEN) plen_next = plen + LEN_W'(1);
        else psat_next = 1'b1;
      end else if (is_pfx && pk != K_NONE) begin
        cont = 1'b0;
        a_v  = 1'b1;
        a_tok.token_kind       = pk;
        a_tok.token_length     = LEN_W'(2);
        a_tok.length_saturated = 1'b0;
        mode_next = M_IDLE;
      end else begin
        a_v       = pend;
        mode_next = M_IDLE;
      end

      if (cont) begin
        if (c.is_ws) begin
          if (c.is_nl) begin
            if (line != POS_MAX) line_next = line + POS_W'(1);
            col_next = '0;
          end
        end else if (c.is_letter || c.is_digit || c.prefix != M_IDLE) begin
          mode_next        = c.is_letter ? M_NAME : (c.is_digit ? M_NUM : c.prefix);
          name_prefix_next = {56'd0, word.value};
          plen_next        = LEN_W'(1);
          psat_next        = 1'b0;
          pline_next       = line;
          pcol_next        = col_in;
        end else begin
          b_v = 1'b1;
          b_tok.token_kind       = (c.single != K_NONE) ? c.single : K_INVALID;
          b_tok.token_length     = LEN_W'(1);
          b_tok.length_saturated = 1'b0;
          b_tok.start_line       = line;
          b_tok.start_column     = col_in;
        end
      end
    end

    w0_valid = go && (a_v || b_v);
    w1_valid = go && a_v && b_v;
    w0 = a_v ? a_tok : b_tok;
    w0.last_of_run = !(a_v && b_v);
    w1 = b_tok;
    w1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      name_prefix <= '0;
      plen        <= '0;
      psat        <= 1'b0;
      pline       <= '0;
      pcol        <= '0;
      line        <= POS_W'(1);
      col         <= '0;
    end else if (go) begin
      mode        <= mode_next;
      name_prefix <= name_prefix_next;
      plen        <= plen_next;
      psat        <= psat_next;
      pline       <= pline_next;
      pcol        <= pcol_next;
      line        <= line_next;
      col         <= col_next;
    end
  end

  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    go && word.cls.is_eoi |=> mode == M_IDLE && line == POS_W'(1) && col == '0)
    else $error("stream did not restart after end marker");

  a_eoi_emits: assert property (@(posedge clk) disable iff (rst)
    go && word.cls.is_eoi |-> w0_valid && (w1_valid ? w1.token_kind == K_EOF
                                                    : w0.token_kind == K_EOF))
    else $error("end marker without end-of-file token");

endmodule

`default_nettype wire

/* sv/stl_out_queue.sv */
// ============================================================================
// stl_out_queue: result queue of the token lexer
// Takes up to two tokens a cycle and presents the oldest one to the consumer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module stl_out_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          w0_valid,
  input  stl_pkg::token_t    w0,
  input  wire logic          w1_valid,
  input  stl_pkg::token_t    w1,
  output logic               room2,
  output logic               empty,
  output stl_pkg::token_t    token,
  input  wire logic          pop
);
  import stl_pkg::*;

  token_t mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wp;
  logic [OQ_AW-1:0] rp;
  logic [OQ_AW:0]   count;
  logic             do_pop;
  logic [OQ_AW:0]   n_push;

  assign empty  = (count == '0);
  assign room2  = (count <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign do_pop = pop && !empty;
  assign token  = mem[rp];
  assign n_push = (OQ_AW+1)'(w0_valid) + (OQ_AW+1)'(w1_valid);

  always_ff @(posedge clk) begin
    if (w0_valid) mem[wp] <= w0;
    if (w1_valid) mem[wp + OQ_AW'(1)] <= w1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push[OQ_AW-1:0];
      if (do_pop) rp <= rp + OQ_AW'(1);
      count <= count + n_push - (OQ_AW+1)'(do_pop);
    end
  end

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    w1_valid |-> w0_valid)
    else $error("second token written without a first");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    w0_valid |-> room2)
    else $error("token written without room for a pair");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue count exceeds depth");

endmodule

`default_nettype wire

/* sv/source_token_lexer_core.sv */
// Each accepted byte is parked in the front queue; the engine takes it from
// there and its tokens are registered in the result queue, oldest first.
// Throughput: one byte per cycle while the result queue has room for a pair;
// a byte that yields two tokens needs two pops, so the pop rate bounds it.
// Reset (synchronous, active high) empties both queues, sets line 1, column 0.
// ============================================================================
// source_token_lexer_core: byte-stream tokenizer
// Groups source bytes into names, keywords, integers and operators, tracking
// the line and column at which each token starts.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module source_token_lexer_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  stl_pkg::item_t     item,
  output logic               full,
  output logic               empty,
  output stl_pkg::token_t    token,
  input  wire logic          pop
);
  import stl_pkg::*;

  // The front classifies each byte (letter, digit, whitespace, operator
  // prefix, single-character punctuation) as it is pushed and parks the
  // result in a four-word queue, so the input side keeps taking words even
  // while the engine waits for room at the output.
  logic        f_avail;
  front_word_t f_head;
  logic        go;

  // Engine results: up to two tokens per byte, written as a pair.
  logic   w0_valid;
  token_t w0;
  logic   w1_valid;
  token_t w1;
  logic   room2;

  stl_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .avail (f_avail),
    .head  (f_head),
    .take  (go)
  );

  // The engine steps only when the result queue can hold a full pair. This
  // keeps the lexer state free of any partial-emit bookkeeping: each byte is
  // finished in the cycle that it is taken.
  assign go = f_avail && room2;

  stl_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .word     (f_head),
    .w0_valid (w0_valid),
    .w0       (w0),
    .w1_valid (w1_valid),
    .w1       (w1)
  );

  // The result queue presents the oldest token; pop takes it when empty is
  // low. A pending name, number or operator prefix flushed together with a new
  // token enters as two words in the same cycle, oldest first.
  stl_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .w0_valid (w0_valid),
    .w0       (w0),
    .w1_valid (w1_valid),
    .w1       (w1),
    .room2    (room2),
    .empty    (empty),
    .token    (token),
    .pop      (pop)
  );

endmodule

`default_nettype wire
